### hdl/vertex_normal_accumulator_defines.svh
// ----------------------------------------------------------------------------
// vertex normal accumulator assertion macros
// shared property forms used by the rtl modules of the block
// ----------------------------------------------------------------------------
`ifndef VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define VNACC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VNACC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/vnacc_pkg.sv
// ----------------------------------------------------------------------------
// vnacc_pkg
// types, codes and constants of the vertex normal accumulator
// ----------------------------------------------------------------------------
package vnacc_pkg;

   localparam int VNACC_MAX_VERTICES = 1024;
   localparam int VNACC_COORD_BITS   = 24;

   localparam int FIELD_COORD_W = 24;
   localparam int IDX_W         = 10;
   localparam int NORM_W        = 16;
   localparam int SUM_W         = 27;
   localparam int SHARE_W       = 12;
   localparam int SHARE_MAX     = 4095;
   localparam int ONE_Q14       = 16384;
   localparam int Q14_SHIFT     = 14;
   localparam int UNIT_W        = 63;
   localparam int FIT_W         = 30;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [1:0] CMD_CLEAR       = 2'd0;
   localparam logic [1:0] CMD_ADD_VERTEX  = 2'd1;
   localparam logic [1:0] CMD_ADD_FACE    = 2'd2;
   localparam logic [1:0] CMD_READ_NORMAL = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NO_FACE    = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX  = 2'd2;
   localparam logic [1:0] STATUS_DEGENERATE = 2'd3;

   typedef enum logic [3:0] {
      OP_CLEAR  = 4'b0001,
      OP_VERTEX = 4'b0010,
      OP_FACE   = 4'b0100,
      OP_READ   = 4'b1000
   } op_type;

   typedef struct packed {
      logic [1:0]                      cmd;
      logic [IDX_W-1:0]                vertex_index;
      logic signed [FIELD_COORD_W-1:0] coord_x;
      logic signed [FIELD_COORD_W-1:0] coord_y;
      logic signed [FIELD_COORD_W-1:0] coord_z;
      logic [IDX_W-1:0]                corner_a;
      logic [IDX_W-1:0]                corner_b;
      logic [IDX_W-1:0]                corner_c;
   } req_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] normal_x;
      logic signed [NORM_W-1:0] normal_y;
      logic signed [NORM_W-1:0] normal_z;
      logic [1:0]               status;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type item;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_head_type;

   typedef struct packed {
      logic                     start;
      logic signed [UNIT_W-1:0] vec_x;
      logic signed [UNIT_W-1:0] vec_y;
      logic signed [UNIT_W-1:0] vec_z;
   } unit_req_type;

   typedef struct packed {
      logic                     done;
      logic                     ok;
      logic signed [NORM_W-1:0] n_x;
      logic signed [NORM_W-1:0] n_y;
      logic signed [NORM_W-1:0] n_z;
   } unit_rsp_type;

endpackage

### hdl/vnacc_front.sv
// ----------------------------------------------------------------------------
// vnacc_front
// accepts request items, decodes the command and queues them for the back end
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_defines.svh"

module vnacc_front
   import vnacc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output q_head_type head,
   input  logic       pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type      entry_ff [QUEUE_DEPTH];
   q_entry_type      entry_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   op_type           op;

   always_comb begin
      case (req_data.cmd)
         CMD_CLEAR:       op = OP_CLEAR;
         CMD_ADD_VERTEX:  op = OP_VERTEX;
         CMD_ADD_FACE:    op = OP_FACE;
         CMD_READ_NORMAL: op = OP_READ;
         default:         op = OP_CLEAR;
      endcase
   end

   assign entry_in  = '{op: op, item: req_data};
   assign req_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

   `VNACC_ASSERT_NOW(a_pop_nonempty, pop, count_ff != '0, "queue popped while empty")
   `VNACC_ASSERT_NEXT(a_push_counts, push && !pop, count_ff == $past(count_ff) + 1'b1,
      "queue count missed a push")

endmodule

### hdl/vnacc_unit.sv
// ----------------------------------------------------------------------------
// vnacc_unit
// iterative unit-vector scaler: range shift, squares, root, Q1.14 division
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_defines.svh"

module vnacc_unit
   import vnacc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  unit_req_type req,
   output unit_rsp_type rsp
);

   localparam int MAG_W = UNIT_W;
   localparam int SQ_W  = 2 * FIT_W + 2;
   localparam int R_W   = FIT_W + 2;
   localparam int DIV_W = FIT_W + Q14_SHIFT + 2;
   localparam int Q_W   = Q14_SHIFT + 1;

   typedef enum logic [6:0] {
      U_IDLE   = 7'b0000001,
      U_SHIFT  = 7'b0000010,
      U_SQUARE = 7'b0000100,
      U_SQRT   = 7'b0001000,
      U_DSET   = 7'b0010000,
      U_DIV    = 7'b0100000,
      U_DONE   = 7'b1000000
   } ustate_type;

   ustate_type               state_ff, state_in;
   logic [MAG_W-1:0]         mag_ff [3];
   logic [MAG_W-1:0]         mag_in [3];
   logic [2:0]               neg_ff, neg_in;
   logic [1:0]               step_ff, step_in;
   logic [2*FIT_W-1:0]       prod_ff, prod_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [SQ_W-1:0]          x_ff, x_in;
   logic [SQ_W-1:0]          r_ff, r_in;
   logic [SQ_W-1:0]          bit_ff, bit_in;
   logic [SQ_W-1:0]          trial;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]         den_ff, den_in;
   logic [Q_W-1:0]           q_ff, q_in;
   logic [Q_W-1:0]           q_next, q_clamp;
   logic [3:0]               qcnt_ff, qcnt_in;
   logic [1:0]               comp_ff, comp_in;
   logic                     ok_ff, ok_in;
   logic signed [NORM_W-1:0] n_ff [3];
   logic signed [NORM_W-1:0] n_in [3];
   logic signed [NORM_W-1:0] q_signed;
   logic [FIT_W-1:0]         sq_op, div_op;
   logic                     all_zero, too_big, take;

   always_comb begin
      all_zero = 1'b1;
      too_big  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (mag_ff[i] != '0) begin
            all_zero = 1'b0;
         end
         if (mag_ff[i][MAG_W-1:FIT_W] != '0) begin
            too_big = 1'b1;
         end
      end
      case (step_ff)
         2'd0:    sq_op = mag_ff[0][FIT_W-1:0];
         2'd1:    sq_op = mag_ff[1][FIT_W-1:0];
         default: sq_op = mag_ff[2][FIT_W-1:0];
      endcase
      case (comp_ff)
         2'd0:    div_op = mag_ff[0][FIT_W-1:0];
         2'd1:    div_op = mag_ff[1][FIT_W-1:0];
         default: div_op = mag_ff[2][FIT_W-1:0];
      endcase
      trial    = r_ff + bit_ff;
      take     = (rem_ff >= den_ff);
      q_next   = {q_ff[Q_W-2:0], take};
      q_clamp  = (q_next > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : q_next;
      q_signed = signed'(NORM_W'(q_clamp));
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      sq_in    = sq_ff;
      x_in     = x_ff;
      r_in     = r_ff;
      bit_in   = bit_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      q_in     = q_ff;
      qcnt_in  = qcnt_ff;
      comp_in  = comp_ff;
      ok_in    = ok_ff;
      n_in     = n_ff;
      case (state_ff)
         U_IDLE: begin
            if (req.start) begin
               neg_in    = {req.vec_z[UNIT_W-1], req.vec_y[UNIT_W-1], req.vec_x[UNIT_W-1]};
               mag_in[0] = req.vec_x[UNIT_W-1] ? MAG_W'(-req.vec_x) : MAG_W'(req.vec_x);
               mag_in[1] = req.vec_y[UNIT_W-1] ? MAG_W'(-req.vec_y) : MAG_W'(req.vec_y);
               mag_in[2] = req.vec_z[UNIT_W-1] ? MAG_W'(-req.vec_z) : MAG_W'(req.vec_z);
               state_in  = U_SHIFT;
            end
         end
         U_SHIFT: begin
            if (all_zero) begin
               ok_in    = 1'b0;
               n_in[0]  = '0;
               n_in[1]  = '0;
               n_in[2]  = '0;
               state_in = U_DONE;
            end else if (too_big) begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end
            end else begin
               ok_in    = 1'b1;
               step_in  = '0;
               sq_in    = '0;
               state_in = U_SQUARE;
            end
         end
         U_SQUARE: begin
            prod_in = sq_op * sq_op;
            if (step_ff != 2'd0) begin
               sq_in = sq_ff + SQ_W'(prod_ff);
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 2'd3) begin
               x_in     = sq_ff + SQ_W'(prod_ff);
               r_in     = '0;
               bit_in   = SQ_W'(1) << (SQ_W - 2);
               state_in = U_SQRT;
            end
         end
         U_SQRT: begin
            if (x_ff >= trial) begin
               x_in = x_ff - trial;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               comp_in  = '0;
               state_in = U_DSET;
            end
         end
         U_DSET: begin
            rem_in   = DIV_W'({div_op, {Q14_SHIFT{1'b0}}}) + DIV_W'(r_ff[R_W-1:1]);
            den_in   = DIV_W'(r_ff[R_W-1:0]) << Q14_SHIFT;
            q_in     = '0;
            qcnt_in  = '0;
            state_in = U_DIV;
         end
         U_DIV: begin
            if (take) begin
               rem_in = rem_ff - den_ff;
            end
            den_in  = den_ff >> 1;
            q_in    = q_next;
            qcnt_in = qcnt_ff + 1'b1;
            if (qcnt_ff == 4'(Q_W - 1)) begin
               n_in[comp_ff] = neg_ff[comp_ff] ? -q_signed : q_signed;
               if (comp_ff == 2'd2) begin
                  state_in = U_DONE;
               end else begin
                  comp_in  = comp_ff + 1'b1;
                  state_in = U_DSET;
               end
            end
         end
         U_DONE: begin
            state_in = U_IDLE;
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      prod_ff <= prod_in;
      sq_ff   <= sq_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      bit_ff  <= bit_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      qcnt_ff <= qcnt_in;
      comp_ff <= comp_in;
      ok_ff   <= ok_in;
      n_ff    <= n_in;
   end

   assign rsp.done = (state_ff == U_DONE);
   assign rsp.ok   = ok_ff;
   assign rsp.n_x  = n_ff[0];
   assign rsp.n_y  = n_ff[1];
   assign rsp.n_z  = n_ff[2];

   `VNACC_ASSERT_NOW(a_start_idle, req.start, state_ff == U_IDLE, "unit started while busy")
   `VNACC_ASSERT_NOW(a_norm_range, rsp.done && rsp.ok,
      rsp.n_x <= 16'sd16384 && rsp.n_x >= -16'sd16384 &&
      rsp.n_y <= 16'sd16384 && rsp.n_y >= -16'sd16384,
      "unit normal out of range")

endmodule

### hdl/vnacc_back.sv
// ----------------------------------------------------------------------------
// vnacc_back
// command sequencer: vertex and sum stores, cross product, accumulation, result
// ----------------------------------------------------------------------------
`include "vertex_normal_accumulator_defines.svh"

module vnacc_back
   import vnacc_pkg::*;
#(
   parameter int MAX_VERTICES = VNACC_MAX_VERTICES,
   parameter int COORD_BITS   = VNACC_COORD_BITS
)
(
   input  logic         clock,
   input  logic         reset,
   input  q_head_type   head,
   output logic         pop,
   output unit_req_type unit_req,
   input  unit_rsp_type unit_rsp,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int D_W    = COORD_BITS + 1;
   localparam int SH_W   = FIT_W + 1;
   localparam int PROD_W = 2 * SH_W;
   localparam logic signed [SUM_W:0] SUM_HI = {2'b00, {(SUM_W - 1){1'b1}}};
   localparam logic signed [SUM_W:0] SUM_LO = {2'b11, {(SUM_W - 1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
   localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_VRD_A  = 13'b0000000000010,
      S_VRD_B  = 13'b0000000000100,
      S_VRD_C  = 13'b0000000001000,
      S_VRD_W  = 13'b0000000010000,
      S_DIFF   = 13'b0000000100000,
      S_MUL    = 13'b0000001000000,
      S_UNIT   = 13'b0000010000000,
      S_ACC_RD = 13'b0000100000000,
      S_ACC_WR = 13'b0001000000000,
      S_SRD    = 13'b0010000000000,
      S_SCHK   = 13'b0100000000000,
      S_RESP   = 13'b1000000000000
   } state_type;

   function automatic logic signed [SUM_W-1:0] sat_add(
      input logic signed [SUM_W-1:0]  s,
      input logic signed [NORM_W-1:0] n
   );
      logic signed [SUM_W:0] t;
      t = (SUM_W + 1)'(s) + (SUM_W + 1)'(n);
      if (t > SUM_HI) begin
         return SUM_HI[SUM_W-1:0];
      end else if (t < SUM_LO) begin
         return SUM_LO[SUM_W-1:0];
      end
      return t[SUM_W-1:0];
   endfunction

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   req_type   item_ff, item_in;
   logic [CNT_W-1:0] count_ff, count_in;

   coord_type vx_mem [MAX_VERTICES];
   coord_type vy_mem [MAX_VERTICES];
   coord_type vz_mem [MAX_VERTICES];
   logic signed [SUM_W-1:0] sx_mem [MAX_VERTICES];
   logic signed [SUM_W-1:0] sy_mem [MAX_VERTICES];
   logic signed [SUM_W-1:0] sz_mem [MAX_VERTICES];
   logic [SHARE_W-1:0]      sh_mem [MAX_VERTICES];

   coord_type               vx_rd_ff, vy_rd_ff, vz_rd_ff;
   logic signed [SUM_W-1:0] sx_rd_ff, sy_rd_ff, sz_rd_ff;
   logic [SHARE_W-1:0]      sh_rd_ff;

   logic                    vert_we, sum_we;
   logic [ADDR_W-1:0]       vert_waddr, vert_raddr, sum_waddr, sum_raddr, corner_addr;
   coord_type               wx, wy, wz, zs;
   logic signed [SUM_W-1:0] wsx, wsy, wsz;
   logic [SHARE_W-1:0]      wsh;

   coord_type cx_ff [3];
   coord_type cy_ff [3];
   coord_type cz_ff [3];

   logic signed [D_W-1:0]    diff  [6];
   logic [D_W-1:0]           dmag  [6];
   logic [D_W-1:0]           orv;
   logic [5:0]               dshift;
   logic [FIT_W-1:0]         m30;
   logic signed [SH_W-1:0]   mpos;
   logic signed [SH_W-1:0]   shr_ff [6];
   logic signed [SH_W-1:0]   shr_in [6];
   logic signed [SH_W-1:0]   op_a, op_b;
   logic [2:0]               step_ff, step_in;
   logic [2:0]               acc_idx;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [UNIT_W-1:0] cr_ff [3];
   logic signed [UNIT_W-1:0] cr_in [3];
   logic signed [UNIT_W-1:0] pext;

   logic [1:0]               corner_ff, corner_in;
   logic signed [NORM_W-1:0] acc_n_ff [3];
   logic signed [NORM_W-1:0] acc_n_in [3];
   rsp_type                  res_ff, res_in;
   rsp_type                  rsp_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_load;
   logic                     head_bad_face, head_bad_read, store_full;

   // request decode checks
   always_comb begin
      store_full    = (count_ff == CNT_W'(MAX_VERTICES));
      head_bad_face = (CMP_W'(head.entry.item.corner_a) >= CMP_W'(count_ff)) ||
                      (CMP_W'(head.entry.item.corner_b) >= CMP_W'(count_ff)) ||
                      (CMP_W'(head.entry.item.corner_c) >= CMP_W'(count_ff));
      head_bad_read = (CMP_W'(head.entry.item.vertex_index) >= CMP_W'(count_ff));
      case (corner_ff)
         2'd0:    corner_addr = ADDR_W'(item_ff.corner_a);
         2'd1:    corner_addr = ADDR_W'(item_ff.corner_b);
         default: corner_addr = ADDR_W'(item_ff.corner_c);
      endcase
   end

   // store ports
   always_comb begin
      zs         = COORD_BITS'(head.entry.item.coord_z);
      wx         = COORD_BITS'(head.entry.item.coord_x);
      wy         = COORD_BITS'(head.entry.item.coord_y);
      wz         = (zs == COORD_MIN) ? COORD_MAX : -zs;
      vert_we    = (state_ff == S_IDLE) && head.valid && (head.entry.op == OP_VERTEX) &&
                   !store_full;
      vert_waddr = ADDR_W'(count_ff);
      case (state_ff)
         S_VRD_A: vert_raddr = ADDR_W'(item_ff.corner_a);
         S_VRD_B: vert_raddr = ADDR_W'(item_ff.corner_b);
         default: vert_raddr = ADDR_W'(item_ff.corner_c);
      endcase
      sum_we    = vert_we || (state_ff == S_ACC_WR);
      sum_waddr = vert_we ? ADDR_W'(count_ff) : corner_addr;
      sum_raddr = (state_ff == S_ACC_RD) ? corner_addr : ADDR_W'(item_ff.vertex_index);
      if (vert_we) begin
         wsx = '0;
         wsy = '0;
         wsz = '0;
         wsh = '0;
      end else begin
         wsx = sat_add(sx_rd_ff, acc_n_ff[0]);
         wsy = sat_add(sy_rd_ff, acc_n_ff[1]);
         wsz = sat_add(sz_rd_ff, acc_n_ff[2]);
         wsh = (sh_rd_ff != SHARE_W'(SHARE_MAX)) ? sh_rd_ff + 1'b1 : sh_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (vert_we) begin
         vx_mem[vert_waddr] <= wx;
         vy_mem[vert_waddr] <= wy;
         vz_mem[vert_waddr] <= wz;
      end
      vx_rd_ff <= vx_mem[vert_raddr];
      vy_rd_ff <= vy_mem[vert_raddr];
      vz_rd_ff <= vz_mem[vert_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sx_mem[sum_waddr] <= wsx;
         sy_mem[sum_waddr] <= wsy;
         sz_mem[sum_waddr] <= wsz;
         sh_mem[sum_waddr] <= wsh;
      end
      sx_rd_ff <= sx_mem[sum_raddr];
      sy_rd_ff <= sy_mem[sum_raddr];
      sz_rd_ff <= sz_mem[sum_raddr];
      sh_rd_ff <= sh_mem[sum_raddr];
   end

   // edge vectors, scaled so every magnitude fits the multiplier
   always_comb begin
      diff[0] = D_W'(cx_ff[1]) - D_W'(cx_ff[0]);
      diff[1] = D_W'(cy_ff[1]) - D_W'(cy_ff[0]);
      diff[2] = D_W'(cz_ff[1]) - D_W'(cz_ff[0]);
      diff[3] = D_W'(cx_ff[2]) - D_W'(cx_ff[0]);
      diff[4] = D_W'(cy_ff[2]) - D_W'(cy_ff[0]);
      diff[5] = D_W'(cz_ff[2]) - D_W'(cz_ff[0]);
      orv = '0;
      for (int i = 0; i < 6; i++) begin
         dmag[i] = diff[i][D_W-1] ? D_W'(-diff[i]) : D_W'(diff[i]);
         orv     = orv | dmag[i];
      end
      dshift = '0;
      for (int p = FIT_W; p < D_W; p++) begin
         if (orv[p]) begin
            dshift = 6'(p - FIT_W + 1);
         end
      end
      for (int i = 0; i < 6; i++) begin
         m30       = FIT_W'(dmag[i] >> dshift);
         mpos      = signed'({1'b0, m30});
         shr_in[i] = diff[i][D_W-1] ? -mpos : mpos;
      end
   end

   // cross product terms, one product per cycle
   always_comb begin
      case (step_ff)
         3'd0:    begin op_a = shr_ff[1]; op_b = shr_ff[5]; end
         3'd1:    begin op_a = shr_ff[2]; op_b = shr_ff[4]; end
         3'd2:    begin op_a = shr_ff[2]; op_b = shr_ff[3]; end
         3'd3:    begin op_a = shr_ff[0]; op_b = shr_ff[5]; end
         3'd4:    begin op_a = shr_ff[0]; op_b = shr_ff[4]; end
         default: begin op_a = shr_ff[1]; op_b = shr_ff[3]; end
      endcase
      acc_idx = step_ff - 1'b1;
      pext    = UNIT_W'(prod_ff);
   end

   assign rsp_load = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);
   assign pop      = (state_ff == S_IDLE) && head.valid;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      prod_in      = prod_ff;
      cr_in        = cr_ff;
      corner_in    = corner_ff;
      acc_n_in     = acc_n_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (head.valid) begin
               op_in        = head.entry.op;
               item_in      = head.entry.item;
               res_in       = '0;
               res_in.status = STATUS_OK;
               state_in     = S_RESP;
               case (head.entry.op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_VERTEX: begin
                     if (store_full) begin
                        res_in.status = STATUS_BAD_INDEX;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_FACE: begin
                     if (head_bad_face) begin
                        res_in.status = STATUS_BAD_INDEX;
                     end else begin
                        state_in = S_VRD_A;
                     end
                  end
                  OP_READ: begin
                     if (head_bad_read) begin
                        res_in.status = STATUS_BAD_INDEX;
                     end else begin
                        state_in = S_SRD;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_VRD_A: state_in = S_VRD_B;
         S_VRD_B: state_in = S_VRD_C;
         S_VRD_C: state_in = S_VRD_W;
         S_VRD_W: state_in = S_DIFF;
         S_DIFF: begin
            step_in  = '0;
            cr_in[0] = '0;
            cr_in[1] = '0;
            cr_in[2] = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in = op_a * op_b;
            if (step_ff != 3'd0 && step_ff != 3'd7) begin
               if (acc_idx[0]) begin
                  cr_in[acc_idx[2:1]] = cr_ff[acc_idx[2:1]] - pext;
               end else begin
                  cr_in[acc_idx[2:1]] = cr_ff[acc_idx[2:1]] + pext;
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd7) begin
               state_in = S_UNIT;
            end
         end
         S_SRD: state_in = S_SCHK;
         S_SCHK: begin
            if (sh_rd_ff == '0) begin
               res_in.status = STATUS_NO_FACE;
               state_in      = S_RESP;
            end else begin
               state_in = S_UNIT;
            end
         end
         S_UNIT: begin
            if (unit_rsp.done) begin
               if (op_ff == OP_FACE) begin
                  acc_n_in[0]   = unit_rsp.n_x;
                  acc_n_in[1]   = unit_rsp.n_y;
                  acc_n_in[2]   = unit_rsp.n_z;
                  res_in.status = unit_rsp.ok ? STATUS_OK : STATUS_DEGENERATE;
                  corner_in     = '0;
                  state_in      = S_ACC_RD;
               end else begin
                  if (unit_rsp.ok) begin
                     res_in.normal_x = unit_rsp.n_x;
                     res_in.normal_y = unit_rsp.n_y;
                     res_in.normal_z = unit_rsp.n_z;
                     res_in.status   = STATUS_OK;
                  end else begin
                     res_in.status = STATUS_NO_FACE;
                  end
                  state_in = S_RESP;
               end
            end
         end
         S_ACC_RD: state_in = S_ACC_WR;
         S_ACC_WR: begin
            if (corner_ff == 2'd2) begin
               state_in = S_RESP;
            end else begin
               corner_in = corner_ff + 1'b1;
               state_in  = S_ACC_RD;
            end
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      unit_req.start = ((state_ff == S_MUL) && (step_ff == 3'd7)) ||
                       ((state_ff == S_SCHK) && (sh_rd_ff != '0));
      if (op_ff == OP_FACE) begin
         unit_req.vec_x = cr_ff[0];
         unit_req.vec_y = cr_ff[1];
         unit_req.vec_z = cr_ff[2];
      end else begin
         unit_req.vec_x = UNIT_W'(sx_rd_ff);
         unit_req.vec_y = UNIT_W'(sy_rd_ff);
         unit_req.vec_z = UNIT_W'(sz_rd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      item_ff   <= item_in;
      step_ff   <= step_in;
      prod_ff   <= prod_in;
      cr_ff     <= cr_in;
      corner_ff <= corner_in;
      acc_n_ff  <= acc_n_in;
      res_ff    <= res_in;
      if (state_ff == S_DIFF) begin
         shr_ff <= shr_in;
      end
      if (state_ff == S_VRD_B) begin
         cx_ff[0] <= vx_rd_ff;
         cy_ff[0] <= vy_rd_ff;
         cz_ff[0] <= vz_rd_ff;
      end
      if (state_ff == S_VRD_C) begin
         cx_ff[1] <= vx_rd_ff;
         cy_ff[1] <= vy_rd_ff;
         cz_ff[1] <= vz_rd_ff;
      end
      if (state_ff == S_VRD_W) begin
         cx_ff[2] <= vx_rd_ff;
         cy_ff[2] <= vy_rd_ff;
         cz_ff[2] <= vz_rd_ff;
      end
      if (rsp_load) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `VNACC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_VERTICES),
      "vertex count beyond store depth")
   `VNACC_ASSERT_NEXT(a_load_valid, rsp_load, rsp_valid_ff, "loaded result not presented")

endmodule

### hdl/vertex_normal_accumulator.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// smoothed per-vertex normals of a triangle mesh in Q1.14
// ----------------------------------------------------------------------------
//  channel   ports                            direction
//  req       req_valid req_ready req_data     in   (command item)
//  rsp       rsp_valid rsp_ready rsp_data     out  (one result per item)
//
//  clear and add vertex go straight to the result; a read also runs the scaler.
//  the shared scaler does one range shift for each bit a face's cross product
//  exceeds 30, then the squares, 31 root steps and one divide per component.
//  a face adds store reads, cross product and writeback around the scaler;
//  reset is synchronous, and the stores need no clearing pass.
//  a two-item queue accepts req until full while the back end works or rsp stalls.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
   import vnacc_pkg::*;
#(
   parameter int MAX_VERTICES = VNACC_MAX_VERTICES,
   parameter int COORD_BITS   = VNACC_COORD_BITS
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   q_head_type   head;
   logic         pop;
   unit_req_type unit_req;
   unit_rsp_type unit_rsp;

   vnacc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   vnacc_unit u_unit (
      .clock (clock),
      .reset (reset),
      .req   (unit_req),
      .rsp   (unit_rsp)
   );

   vnacc_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_BITS   (COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .unit_req  (unit_req),
      .unit_rsp  (unit_rsp),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
